// ----- design/rsd_pkg.sv -----
// Shared types and constants for the RTPS submessage deframer.
// Used by every module in the design folder; depends on nothing.
package rsd_pkg;

   localparam int unsigned MSG_HDR_LEN    = 20;
   localparam int unsigned HDR_STORE_BITS = (MSG_HDR_LEN - 1) * 8;
   localparam int unsigned HDR_FULL_BITS  = MSG_HDR_LEN * 8;
   localparam int unsigned RSP_TDATA_W    = 176;
   localparam logic [31:0] MAGIC_WORD     = 32'h5254_5053; // "RTPS"

   typedef enum logic [1:0] {
      KIND_MSG_HEADER = 2'd0,
      KIND_SUB_HEADER = 2'd1,
      KIND_BODY_BYTE  = 2'd2,
      KIND_ERROR      = 2'd3
   } rsd_kind_type;

   typedef enum logic [4:0] {
      PH_MSG      = 5'b00001,
      PH_SUBHDR   = 5'b00010,
      PH_BODY     = 5'b00100,
      PH_BODY_END = 5'b01000,
      PH_PAD      = 5'b10000
   } rsd_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eom;
   } rsd_item_type;

   typedef struct packed {
      rsd_kind_type kind;
      logic [7:0]   body_byte;
      logic         last;
      logic [7:0]   sub_id;
      logic [7:0]   sub_flags;
      logic [15:0]  sub_length;
      logic         runs_to_end;
      logic         magic_ok;
      logic [15:0]  protocol_version;
      logic [15:0]  vendor_code;
      logic [31:0]  prefix_high;
      logic [63:0]  prefix_low;
   } rsd_result_type;

endpackage

// ----- design/rsd_input_stage.sv -----
// Input register of the deframer: holds one byte transaction for the parser.
// Depends on rsd_pkg.
module rsd_input_stage
   import rsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // byte_in
   input  logic         req_tlast,   // end_of_message
   input  logic         advance_ok,
   output logic         item_fire,
   output rsd_item_type item
);

   logic         valid_ff, valid_in;
   rsd_item_type item_ff;

   assign req_tready = !valid_ff || advance_ok;
   assign item_fire  = valid_ff && advance_ok;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (item_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= '{data: req_tdata, eom: req_tlast};
      end
   end

endmodule

// ----- design/rsd_parser_core.sv -----
// Per-byte parse state machine: message header capture, submessage headers,
// body bytes and alignment padding. Depends on rsd_pkg.
module rsd_parser_core
   import rsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           item_fire,
   input  rsd_item_type   item,
   output logic           res_valid,
   output rsd_result_type res
);

   rsd_phase_type             phase_ff, phase_in;
   logic [4:0]                byte_index_ff, byte_index_in;
   logic [1:0]                align_ff, align_in;
   logic [15:0]               remaining_ff, remaining_in;
   logic                      first_ff, first_in;
   logic [7:0]                held_id_ff, held_id_in;
   logic [7:0]                held_flags_ff, held_flags_in;
   logic [7:0]                held_len_ff, held_len_in;
   logic [HDR_STORE_BITS-1:0] hdr_ff, hdr_in;

   logic [HDR_FULL_BITS-1:0]  hdr_full;
   logic [15:0]               sub_len;
   logic [15:0]               rem_next;

   assign hdr_full = {hdr_ff, item.data};
   assign sub_len  = held_flags_ff[0] ? {item.data, held_len_ff} : {held_len_ff, item.data};
   assign rem_next = remaining_ff - {15'd0, (remaining_ff != 16'd0)};

   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      align_in      = align_ff;
      remaining_in  = remaining_ff;
      first_in      = first_ff;
      held_id_in    = held_id_ff;
      held_flags_in = held_flags_ff;
      held_len_in   = held_len_ff;
      hdr_in        = hdr_ff;
      res_valid     = 1'b0;
      res           = '0;

      case (phase_ff)
         PH_MSG: begin
            hdr_in = hdr_full[HDR_STORE_BITS-1:0];
            if (byte_index_ff >= 5'(MSG_HDR_LEN - 1)) begin
               res_valid            = 1'b1;
               res.kind             = KIND_MSG_HEADER;
               res.magic_ok         = (hdr_full[159:128] == MAGIC_WORD);
               res.protocol_version = hdr_full[127:112];
               res.vendor_code      = hdr_full[111:96];
               res.prefix_high      = hdr_full[95:64];
               res.prefix_low       = hdr_full[63:0];
               phase_in             = PH_SUBHDR;
               byte_index_in        = 5'd0;
            end else begin
               byte_index_in = byte_index_ff + 5'd1;
               if (item.eom) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_ERROR;
               end
            end
         end
         PH_SUBHDR: begin
            if (byte_index_ff == 5'd0) begin
               held_id_in    = item.data;
               byte_index_in = 5'd1;
            end else if (byte_index_ff == 5'd1) begin
               held_flags_in = item.data;
               byte_index_in = 5'd2;
            end else if (byte_index_ff == 5'd2) begin
               held_len_in   = item.data;
               byte_index_in = 5'd3;
            end else begin
               byte_index_in = 5'd0;
               first_in      = 1'b0;
               res_valid     = 1'b1;
               res.kind      = KIND_SUB_HEADER;
               if (sub_len == 16'd0 && first_ff) begin
                  // zero length on the first submessage: body runs to end mark
                  res.runs_to_end = 1'b1;
                  if (item.eom) begin
                     res.last = 1'b1;
                  end else begin
                     phase_in = PH_BODY_END;
                  end
               end else if (sub_len == 16'd0) begin
                  res.last = 1'b1;
               end else if (item.eom) begin
                  res.kind = KIND_ERROR;
               end else begin
                  remaining_in = sub_len;
                  align_in     = 2'd0;
                  phase_in     = PH_BODY;
               end
               if (res.kind == KIND_SUB_HEADER) begin
                  res.sub_id     = held_id_ff;
                  res.sub_flags  = held_flags_ff;
                  res.sub_length = sub_len;
               end
            end
         end
         PH_BODY: begin
            align_in  = align_ff + 2'd1;
            res_valid = 1'b1;
            if (item.eom && remaining_ff > 16'd1) begin
               res.kind = KIND_ERROR;
            end else begin
               res.kind      = KIND_BODY_BYTE;
               res.body_byte = item.data;
               remaining_in  = rem_next;
               if (rem_next == 16'd0) begin
                  res.last = 1'b1;
                  phase_in = (align_in != 2'd0) ? PH_PAD : PH_SUBHDR;
               end
            end
         end
         PH_BODY_END: begin
            res_valid     = 1'b1;
            res.kind      = KIND_BODY_BYTE;
            res.body_byte = item.data;
            res.last      = item.eom;
         end
         PH_PAD: begin
            align_in = align_ff + 2'd1;
            if (align_in == 2'd0) begin
               phase_in = PH_SUBHDR;
            end
         end
         default: begin
            phase_in      = PH_MSG;
            byte_index_in = 5'd0;
            align_in      = 2'd0;
            remaining_in  = 16'd0;
            first_in      = 1'b1;
         end
      endcase

      // end mark: start over on a new message
      if (item.eom) begin
         phase_in      = PH_MSG;
         byte_index_in = 5'd0;
         align_in      = 2'd0;
         remaining_in  = 16'd0;
         first_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MSG;
         byte_index_ff <= 5'd0;
         align_ff      <= 2'd0;
         remaining_ff  <= 16'd0;
         first_ff      <= 1'b1;
      end else if (item_fire) begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         align_ff      <= align_in;
         remaining_ff  <= remaining_in;
         first_ff      <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         held_id_ff    <= held_id_in;
         held_flags_ff <= held_flags_in;
         held_len_ff   <= held_len_in;
         hdr_ff        <= hdr_in;
      end
   end

`ifndef SYNTHESIS
   a_body_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> remaining_ff != 16'd0)
      else $error("body phase with nothing left to pass");

   a_subhdr_aligned: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SUBHDR |-> align_ff == 2'd0 && byte_index_ff <= 5'd3)
      else $error("submessage header out of alignment");

   a_msg_index_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_MSG |-> byte_index_ff < 5'(MSG_HDR_LEN))
      else $error("message header index past header");

   a_eom_restarts: assert property (@(posedge clock) disable iff (reset)
      item_fire && item.eom |=> phase_ff == PH_MSG && byte_index_ff == 5'd0 && first_ff)
      else $error("end of message did not restart parse");
`endif

endmodule

// ----- design/rsd_output_stage.sv -----
// Result register of the deframer: holds one result transaction until taken.
// Depends on rsd_pkg.
module rsd_output_stage
   import rsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  rsd_result_type         res,
   output logic                   room,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic [1:0]             rsp_tuser
);

   logic           valid_ff, valid_in;
   rsd_result_type res_ff;

   assign room       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = res_ff.last;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {6'd0, res_ff.prefix_low, res_ff.prefix_high, res_ff.vendor_code,
                        res_ff.protocol_version, res_ff.magic_ok, res_ff.runs_to_end,
                        res_ff.sub_length, res_ff.sub_flags, res_ff.sub_id,
                        res_ff.body_byte};

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

endmodule

// ----- design/rtps_submessage_deframer_unit.sv -----
// RTPS submessage deframer, top level. Takes one message byte per transaction
// (tlast on the final byte) and returns header, body and error results; it
// depends on rsd_pkg, rsd_input_stage, rsd_parser_core and rsd_output_stage.
// A byte is accepted in every clock while results are being taken; a byte's
// result, if it has one, is offered after the byte has sat in the input
// register through the parse logic and its result has been loaded into the
// result register; an untaken result stalls that load. Padding bytes and
// trailing bytes too short for a submessage header give no result.
// No memories, so no start-up pass after reset.
module rtps_submessage_deframer_unit
   import rsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,  // [7:0] byte_in
   input  logic                   req_tlast,  // end_of_message
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] body_byte, [15:8] submessage_id, [23:16] submessage_flags,
   // [39:24] submessage_length, [40] runs_to_end, [41] magic_ok,
   // [57:42] protocol_version, [73:58] vendor_code, [105:74] prefix_high,
   // [169:106] prefix_low, [175:170] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,  // last_of_submessage
   output logic [1:0]             rsp_tuser   // [1:0] kind
);

   logic           room;
   logic           item_fire;
   rsd_item_type   item;
   logic           res_valid;
   rsd_result_type res;

   rsd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance_ok (room),
      .item_fire  (item_fire),
      .item       (item)
   );

   rsd_parser_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   rsd_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (item_fire && res_valid),
      .res        (res),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for rtps_submessage_deframer_unit: byte streams of RTPS messages in,
// header, body and error results out, checked against a built-in parser model.
// Depends on rsd_pkg and the design folder only.
module testbench;
   import rsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD   = 300;
   localparam int RANDOM_BYTES = 2000;

   // Parser model plus the queue of results it expects from the block
   class deframe_scoreboard;
      rsd_phase_type  phase;
      logic [4:0]     byte_index;
      logic [1:0]     align_offset;
      logic [15:0]    body_remaining;
      bit             first_sub;
      bit             order_little;
      logic [7:0]     held_id;
      logic [7:0]     held_flags;
      logic [7:0]     held_len_byte;
      logic [63:0]    hdr_store [3];
      rsd_result_type expected_q [$];
      int             errors;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase          = PH_MSG;
         byte_index     = '0;
         align_offset   = '0;
         body_remaining = '0;
         first_sub      = 1'b1;
         order_little   = 1'b0;
         held_id        = '0;
         held_flags     = '0;
         held_len_byte  = '0;
         foreach (hdr_store[i]) hdr_store[i] = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // One accepted byte; queues the result it causes, if any
      function void note_byte(logic [7:0] b, logic eom);
         rsd_result_type r;
         bit             has;
         int             slot;
         logic [15:0]    len;
         r   = '0;
         has = 1'b0;
         case (phase)
            PH_MSG: begin
               slot = int'(byte_index >> 3);
               if (slot > 2) slot = 2;
               hdr_store[slot] = {hdr_store[slot][55:0], b};
               if (byte_index >= 5'(MSG_HDR_LEN - 1)) begin
                  r.kind             = KIND_MSG_HEADER;
                  r.magic_ok         = (hdr_store[0][63:32] == MAGIC_WORD);
                  r.protocol_version = hdr_store[0][31:16];
                  r.vendor_code      = hdr_store[0][15:0];
                  r.prefix_high      = hdr_store[1][63:32];
                  r.prefix_low       = {hdr_store[1][31:0], hdr_store[2][31:0]};
                  has        = 1'b1;
                  phase      = PH_SUBHDR;
                  byte_index = '0;
               end else begin
                  byte_index = byte_index + 5'd1;
                  if (eom) begin
                     r.kind = KIND_ERROR;
                     has    = 1'b1;
                  end
               end
            end
            PH_SUBHDR: begin
               case (byte_index)
                  5'd0: begin
                     held_id    = b;
                     byte_index = 5'd1;
                  end
                  5'd1: begin
                     held_flags   = b;
                     order_little = b[0];
                     byte_index   = 5'd2;
                  end
                  5'd2: begin
                     held_len_byte = b;
                     byte_index    = 5'd3;
                  end
                  default: begin
                     len        = order_little ? {b, held_len_byte} : {held_len_byte, b};
                     byte_index = '0;
                     has        = 1'b1;
                     if (len == 16'd0 && first_sub) begin
                        r.kind        = KIND_SUB_HEADER;
                        r.runs_to_end = 1'b1;
                        if (eom) r.last = 1'b1;
                        else phase = PH_BODY_END;
                     end else if (len == 16'd0) begin
                        r.kind = KIND_SUB_HEADER;
                        r.last = 1'b1;
                     end else if (eom) begin
                        r.kind = KIND_ERROR;
                     end else begin
                        r.kind         = KIND_SUB_HEADER;
                        body_remaining = len;
                        align_offset   = '0;
                        phase          = PH_BODY;
                     end
                     if (r.kind == KIND_SUB_HEADER) begin
                        r.sub_id     = held_id;
                        r.sub_flags  = held_flags;
                        r.sub_length = len;
                     end
                     first_sub = 1'b0;
                  end
               endcase
            end
            PH_BODY: begin
               align_offset = align_offset + 2'd1;
               has          = 1'b1;
               if (eom && body_remaining > 16'd1) begin
                  r.kind = KIND_ERROR;
               end else begin
                  r.kind      = KIND_BODY_BYTE;
                  r.body_byte = b;
                  if (body_remaining > 16'd0) body_remaining = body_remaining - 16'd1;
                  if (body_remaining == 16'd0) begin
                     r.last = 1'b1;
                     phase  = (align_offset != 2'd0) ? PH_PAD : PH_SUBHDR;
                  end
               end
            end
            PH_BODY_END: begin
               has         = 1'b1;
               r.kind      = KIND_BODY_BYTE;
               r.body_byte = b;
               r.last      = eom;
            end
            PH_PAD: begin
               align_offset = align_offset + 2'd1;
               if (align_offset == 2'd0) phase = PH_SUBHDR;
            end
            default: clear_state();
         endcase
         if (eom) clear_state();
         if (has) expected_q.push_back(r);
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 40) $display("ERROR at %0t ns: %s", $time, what);
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
      endtask

      task check_result(logic [1:0] kind, logic last, logic [RSP_TDATA_W-1:0] data);
         rsd_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result of kind %0d with none outstanding", kind));
            return;
         end
         want = expected_q.pop_front();
         compare_field("kind", 64'(kind), 64'(want.kind));
         compare_field("last", 64'(last), 64'(want.last));
         compare_field("body_byte", 64'(data[7:0]), 64'(want.body_byte));
         compare_field("submessage_id", 64'(data[15:8]), 64'(want.sub_id));
         compare_field("submessage_flags", 64'(data[23:16]), 64'(want.sub_flags));
         compare_field("submessage_length", 64'(data[39:24]), 64'(want.sub_length));
         compare_field("runs_to_end", 64'(data[40]), 64'(want.runs_to_end));
         compare_field("magic_ok", 64'(data[41]), 64'(want.magic_ok));
         compare_field("protocol_version", 64'(data[57:42]), 64'(want.protocol_version));
         compare_field("vendor_code", 64'(data[73:58]), 64'(want.vendor_code));
         compare_field("prefix_high", 64'(data[105:74]), 64'(want.prefix_high));
         compare_field("prefix_low", data[169:106], want.prefix_low);
         compare_field("tdata fill", 64'(data[175:170]), 64'd0);
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic [1:0]             rsp_tuser;

   deframe_scoreboard sb;
   logic [7:0]        msg_bytes [$];
   int                sent_bytes  = 0;
   bit                quiet       = 1'b0;
   bit                hold_output = 1'b0;

   rtps_submessage_deframer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly back to back, now and then a long gap
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tlast, rsp_tdata);
      end
   end

   initial begin : receiver
      int stall;
      forever begin
         if (hold_output) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_output = 1'b0;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic add_header(logic [31:0] magic, bit rand_rest, logic [7:0] fill);
      for (int i = 3; i >= 0; i--) msg_bytes.push_back(magic[8*i +: 8]);
      repeat (16) msg_bytes.push_back(rand_rest ? 8'($urandom) : fill);
   endtask

   // Header, body of nbody random bytes, padding to a 4-byte boundary if pad is set
   task automatic add_submessage(logic [7:0] id, logic [7:0] flags, logic [15:0] len,
                                 int nbody, bit pad);
      msg_bytes.push_back(id);
      msg_bytes.push_back(flags);
      if (flags[0]) begin
         msg_bytes.push_back(len[7:0]);
         msg_bytes.push_back(len[15:8]);
      end else begin
         msg_bytes.push_back(len[15:8]);
         msg_bytes.push_back(len[7:0]);
      end
      repeat (nbody) msg_bytes.push_back(8'($urandom));
      if (pad) repeat ((4 - nbody % 4) % 4) msg_bytes.push_back(8'($urandom));
   endtask

   task automatic trim_message(int keep);
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
   endtask

   // End of message is marked on the final queued byte
   task automatic send_message();
      int gap;
      quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < msg_bytes.size(); i++) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= msg_bytes[i];
         req_tlast  <= (i == msg_bytes.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      sent_bytes += msg_bytes.size();
      msg_bytes.delete();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_message();
      int          style;
      int          nsub;
      int          roll;
      int          nbody;
      bit          cut_short;
      logic [15:0] len;
      style = $urandom_range(0, 99);
      if (style < 6) begin
         repeat ($urandom_range(1, 40)) msg_bytes.push_back(8'($urandom));
      end else begin
         add_header(($urandom_range(0, 9) == 0) ? 32'($urandom) : MAGIC_WORD, 1'b1, 8'h00);
         nsub = $urandom_range(0, 4);
         for (int s = 0; s < nsub; s++) begin
            roll      = $urandom_range(0, 99);
            cut_short = 1'b0;
            if (roll < 12) begin
               len   = 16'd0;
               nbody = (s == 0) ? $urandom_range(0, 10) : 0;
            end else if (roll < 16) begin
               // long length, message ends a few body bytes in
               len       = 16'($urandom_range(256, 65535));
               nbody     = $urandom_range(0, 6);
               cut_short = 1'b1;
            end else begin
               len   = (roll < 24) ? 16'($urandom_range(13, 48)) : 16'($urandom_range(1, 12));
               nbody = int'(len);
            end
            add_submessage(8'($urandom), 8'($urandom), len, nbody,
                           (s != nsub - 1) || ($urandom_range(0, 1) == 1));
            if (cut_short) break;
         end
         if (style < 16) trim_message($urandom_range(1, msg_bytes.size()));
         else if (style < 24) repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
      end
      send_message();
   endtask

   initial begin : watchdog
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      bit paused;
      sb     = new();
      paused = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // message cut after one byte, then after the magic
      msg_bytes.push_back(8'h52);
      send_message();
      add_header(MAGIC_WORD, 1'b0, 8'h00);
      trim_message(4);
      send_message();
      // header alone, every field after the magic at its top value
      add_header(MAGIC_WORD, 1'b0, 8'hFF);
      send_message();
      // bad magic; big and little endian bodies, padding, empty submessage at the end
      add_header(32'h0000_0000, 1'b0, 8'h00);
      add_submessage(8'h15, 8'h00, 16'd4, 4, 1'b1);
      add_submessage(8'h09, 8'h01, 16'd1, 1, 1'b1);
      add_submessage(8'hFF, 8'hFE, 16'd0, 0, 1'b0);
      send_message();
      // zero length first submessage runs to the end, with a body and without
      add_header(MAGIC_WORD, 1'b1, 8'h00);
      add_submessage(8'h15, 8'h01, 16'd0, 3, 1'b0);
      send_message();
      add_header(MAGIC_WORD, 1'b1, 8'h00);
      add_submessage(8'h07, 8'h00, 16'd0, 0, 1'b0);
      send_message();
      // truncated bodies: full-scale length, and end on the last length byte
      add_header(MAGIC_WORD, 1'b1, 8'h00);
      add_submessage(8'h15, 8'h01, 16'hFFFF, 2, 1'b0);
      send_message();
      add_header(MAGIC_WORD, 1'b1, 8'h00);
      add_submessage(8'h07, 8'h01, 16'd4, 4, 1'b0);
      add_submessage(8'h15, 8'h00, 16'd8, 0, 1'b0);
      send_message();
      // ends inside padding, then trailing bytes too few for a header
      add_header(MAGIC_WORD, 1'b1, 8'h00);
      add_submessage(8'h15, 8'h00, 16'd2, 2, 1'b1);
      send_message();
      add_header(MAGIC_WORD, 1'b1, 8'h00);
      add_submessage(8'h0E, 8'h01, 16'd4, 4, 1'b0);
      msg_bytes.push_back(8'h0A);
      msg_bytes.push_back(8'hF5);
      send_message();
      wait_drained();

      // output held off at the start so the block backs up
      hold_output = 1'b1;
      sent_bytes  = 0;
      while (sent_bytes < RANDOM_BYTES) begin
         random_message();
         if (!paused && sent_bytes >= RANDOM_BYTES / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
